### design/cantp_pkg.sv
// shared types, register indexes and the hex digit decoder of the can text frame parser
package cantp_pkg;

   // configuration register indexes
   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] CSR_CTRL_ID         = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_STOP_VALUE      = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_START_PAYLOAD_A = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_START_PAYLOAD_B = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_START_COUNT     = 3'd4;

   localparam int unsigned CSR_DATA_W = 64;
   localparam int unsigned ID_W       = 12;
   localparam int unsigned PAYLOAD_W  = 64;
   localparam int unsigned CHAR_W     = 8;

   // stream widths: request carries one character, response carries id and payload
   localparam int unsigned REQ_TDATA_W = 8;
   localparam int unsigned RSP_TDATA_W = 80;
   localparam int unsigned RSP_TUSER_W = 3;

   localparam logic [CHAR_W-1:0] CHAR_HASH = 8'h23;

   typedef struct packed {
      logic [ID_W-1:0]      ctrl_id;
      logic [PAYLOAD_W-1:0] stop_value;
      logic [PAYLOAD_W-1:0] start_payload_a;
      logic [PAYLOAD_W-1:0] start_payload_b;
      logic [1:0]           start_count;
   } cfg_type;

   typedef struct packed {
      logic                 frame_valid;
      logic [ID_W-1:0]      frame_id;
      logic [PAYLOAD_W-1:0] frame_payload;
   } frame_type;

   typedef struct packed {
      logic       is_hex;
      logic [3:0] value;
   } hex_type;

   // ascii hex digit, either case
   function automatic hex_type hex_decode(logic [CHAR_W-1:0] c);
      hex_type r;
      r.is_hex = 1'b0;
      r.value  = 4'd0;
      priority if (c >= 8'h30 && c <= 8'h39) begin
         r.is_hex = 1'b1;
         r.value  = c[3:0];
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         r.is_hex = 1'b1;
         r.value  = c[3:0] + 4'd9;
      end else begin
         r.is_hex = 1'b0;
      end
      return r;
   endfunction

endpackage

### design/cantp_parse.sv
// character parser: per-frame state, digit accumulation and the frame result register
module cantp_parse #(
   parameter int unsigned MAX_PAYLOAD_BYTES = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_vld,
   input  logic [7:0]               in_char,
   input  logic                     in_last,
   output logic                     in_take,
   output cantp_pkg::frame_type     res,
   output logic                     res_vld,
   input  logic                     res_take
);
   import cantp_pkg::*;

   localparam int unsigned CW = $clog2(2 * MAX_PAYLOAD_BYTES + 1);
   localparam logic [CW-1:0] PL_LIMIT = CW'(2 * MAX_PAYLOAD_BYTES);

   // parse phases
   localparam logic [1:0] PH_ID      = 2'd0;
   localparam logic [1:0] PH_HASH    = 2'd1;
   localparam logic [1:0] PH_PAYLOAD = 2'd2;

   logic [1:0]           phase_ff, phase_in;
   logic [1:0]           id_cnt_ff, id_cnt_in;
   logic [ID_W-1:0]      id_acc_ff, id_acc_in;
   logic [PAYLOAD_W-1:0] pl_acc_ff, pl_acc_in;
   logic [CW-1:0]        pl_cnt_ff, pl_cnt_in;
   logic                 err_ff, err_in;
   frame_type            res_ff, res_in;
   logic                 res_vld_ff;
   hex_type              dig;
   logic                 frame_ok;

   assign dig     = hex_decode(in_char);
   assign in_take = in_vld && (!in_last || !res_vld_ff || res_take);
   assign res     = res_ff;
   assign res_vld = res_vld_ff;

   // next parse state for the current character
   always_comb begin
      phase_in  = phase_ff;
      id_cnt_in = id_cnt_ff;
      id_acc_in = id_acc_ff;
      pl_acc_in = pl_acc_ff;
      pl_cnt_in = pl_cnt_ff;
      err_in    = err_ff;
      if (!err_ff) begin
         unique case (phase_ff)
            PH_ID: begin
               if (!dig.is_hex) begin
                  err_in = 1'b1;
               end else begin
                  id_acc_in = {id_acc_ff[ID_W-5:0], dig.value};
                  id_cnt_in = id_cnt_ff + 2'd1;
                  if (id_cnt_ff == 2'd2) begin
                     phase_in = PH_HASH;
                  end
               end
            end
            PH_HASH: begin
               if (in_char == CHAR_HASH) begin
                  phase_in = PH_PAYLOAD;
               end else begin
                  err_in = 1'b1;
               end
            end
            PH_PAYLOAD: begin
               if (!dig.is_hex || pl_cnt_ff >= PL_LIMIT) begin
                  err_in = 1'b1;
               end else begin
                  pl_acc_in = {pl_acc_ff[PAYLOAD_W-5:0], dig.value};
                  pl_cnt_in = pl_cnt_ff + CW'(1);
               end
            end
            default: begin
               err_in = 1'b1;
            end
         endcase
      end
   end

   // frame verdict at the last character
   always_comb begin
      frame_ok = !err_in && (phase_in == PH_PAYLOAD) && (pl_cnt_in >= CW'(2))
                 && !pl_cnt_in[0];
      res_in.frame_valid   = frame_ok;
      res_in.frame_id      = frame_ok ? id_acc_in : '0;
      res_in.frame_payload = frame_ok ? pl_acc_in : '0;
   end

   // parse state, cleared after every last character
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_ID;
         id_cnt_ff <= '0;
         id_acc_ff <= '0;
         pl_acc_ff <= '0;
         pl_cnt_ff <= '0;
         err_ff    <= 1'b0;
      end else if (in_take) begin
         if (in_last) begin
            phase_ff  <= PH_ID;
            id_cnt_ff <= '0;
            id_acc_ff <= '0;
            pl_acc_ff <= '0;
            pl_cnt_ff <= '0;
            err_ff    <= 1'b0;
         end else begin
            phase_ff  <= phase_in;
            id_cnt_ff <= id_cnt_in;
            id_acc_ff <= id_acc_in;
            pl_acc_ff <= pl_acc_in;
            pl_cnt_ff <= pl_cnt_in;
            err_ff    <= err_in;
         end
      end
   end

   // frame result register
   always_ff @(posedge clock) begin
      if (reset) begin
         res_vld_ff <= 1'b0;
      end else if (in_take && in_last) begin
         res_vld_ff <= 1'b1;
      end else if (res_take) begin
         res_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take && in_last) begin
         res_ff <= res_in;
      end
   end

   // a rejected frame reports zero id and payload
   a_bad_frame_zero: assert property (@(posedge clock) disable iff (reset)
      res_vld_ff && !res_ff.frame_valid |-> res_ff.frame_id == '0 && res_ff.frame_payload == '0)
      else $error("malformed frame result carries nonzero id or payload");

   // state is clean after a frame ends
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      in_take && in_last |=> phase_ff == PH_ID && id_cnt_ff == 2'd0 && pl_cnt_ff == '0
                             && !err_ff)
      else $error("parse state not cleared after last character");

   // payload digit count stays within the frame limit
   a_pl_cnt_limit: assert property (@(posedge clock) disable iff (reset)
      pl_cnt_ff <= PL_LIMIT)
      else $error("payload digit count beyond limit");

   // a waiting result is held until taken
   a_res_hold: assert property (@(posedge clock) disable iff (reset)
      res_vld_ff && !res_take |=> res_vld_ff && $stable(res_ff))
      else $error("frame result lost while stalled");

endmodule

### design/cantp_match.sv
// control frame matching and the response output register
module cantp_match (
   input  logic                                  clock,
   input  logic                                  reset,
   input  cantp_pkg::cfg_type                    cfg,
   input  cantp_pkg::frame_type                  res,
   input  logic                                  res_vld,
   output logic                                  res_take,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [cantp_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic [cantp_pkg::RSP_TUSER_W-1:0]     rsp_tuser
);
   import cantp_pkg::*;

   logic      out_vld_ff;
   frame_type out_frame_ff;
   logic      out_start_ff, out_stop_ff;
   logic      special, start_hit, start_in, stop_in;

   assign res_take = res_vld && (!out_vld_ff || rsp_tready);

   // compare against the configured control values
   always_comb begin
      special   = (res.frame_id == cfg.ctrl_id);
      start_hit = ((cfg.start_count >= 2'd1) && (res.frame_payload == cfg.start_payload_a))
               || ((cfg.start_count >= 2'd2) && (res.frame_payload == cfg.start_payload_b));
      start_in  = special && start_hit;
      stop_in   = special && (res.frame_payload == cfg.stop_value);
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (res_take) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         out_frame_ff <= res;
         out_start_ff <= start_in;
         out_stop_ff  <= stop_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - ID_W - PAYLOAD_W){1'b0}},
                        out_frame_ff.frame_payload, out_frame_ff.frame_id};
   assign rsp_tuser  = {out_stop_ff, out_start_ff, out_frame_ff.frame_valid};

   // control flags need the control id
   a_flags_need_id: assert property (@(posedge clock) disable iff (reset)
      res_take && (res.frame_id != cfg.ctrl_id) |=> !out_start_ff && !out_stop_ff)
      else $error("control flag raised on a non-control id");

   // no start match when no start payload is enabled
   a_start_disabled: assert property (@(posedge clock) disable iff (reset)
      res_take && cfg.start_count == 2'd0 |=> !out_start_ff)
      else $error("start flag raised with start payloads disabled");

   // a result is taken only into a free or draining output register
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !rsp_tready |=> out_vld_ff && $stable(out_frame_ff))
      else $error("response overwritten while stalled");

endmodule

### design/can_text_frame_parser.sv
// top level of the can text frame parser: ports, configuration registers, input register
//
// The request stream carries one ASCII character per transfer in req_tdata, with
// req_tlast marking the character that ends the frame text. A frame is three hex
// digits, '#', then an even count of 2 to 2*MAX_PAYLOAD_BYTES hex digits.
// For each last character one response comes out: id and payload in rsp_tdata,
// the valid, start and stop flags in rsp_tuser. Non-last characters give none.
// Throughput is one character per cycle while req_tready stays high; the parse step
// between the input register and the frame result register is combinational.
// A last character passes the input register, the frame result register and the
// output register in that order before its response shows on rsp_tvalid.
// When the receiver stalls, the output register and the frame result register
// hold up to two responses; non-last characters keep flowing, and req_tready
// drops only once a last character finds both held.
// Configuration is written through csr_we/csr_addr/csr_wdata while the block is
// idle; indexes past the register list are ignored.
// A synchronous reset clears the parse state, all valid flags and every
// configuration register to zero; no clearing pass is needed.
module can_text_frame_parser #(
   parameter int unsigned MAX_PAYLOAD_BYTES = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request: [7:0] text_char
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [cantp_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic                                  req_tlast,
   // response: [11:0] frame_id, [75:12] frame_payload, [79:76] zero
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [cantp_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // response: [0] frame_valid, [1] start_flag, [2] stop_flag
   output logic [cantp_pkg::RSP_TUSER_W-1:0]     rsp_tuser,
   input  logic                                  csr_we,
   input  logic [cantp_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [cantp_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import cantp_pkg::*;

   cfg_type          cfg_ff;
   logic             in_vld_ff;
   logic [CHAR_W-1:0] in_char_ff;
   logic             in_last_ff;
   logic             in_take;
   frame_type        res;
   logic             res_vld, res_take;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_CTRL_ID:         cfg_ff.ctrl_id         <= csr_wdata[ID_W-1:0];
            CSR_STOP_VALUE:      cfg_ff.stop_value      <= csr_wdata[PAYLOAD_W-1:0];
            CSR_START_PAYLOAD_A: cfg_ff.start_payload_a <= csr_wdata[PAYLOAD_W-1:0];
            CSR_START_PAYLOAD_B: cfg_ff.start_payload_b <= csr_wdata[PAYLOAD_W-1:0];
            CSR_START_COUNT:     cfg_ff.start_count     <= csr_wdata[1:0];
            default: begin
            end
         endcase
      end
   end

   // input register
   assign req_tready = !in_vld_ff || in_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_char_ff <= req_tdata[CHAR_W-1:0];
         in_last_ff <= req_tlast;
      end
   end

   cantp_parse #(
      .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
   ) u_parse (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (in_vld_ff),
      .in_char  (in_char_ff),
      .in_last  (in_last_ff),
      .in_take  (in_take),
      .res      (res),
      .res_vld  (res_vld),
      .res_take (res_take)
   );

   cantp_match u_match (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .res        (res),
      .res_vld    (res_vld),
      .res_take   (res_take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### bench/tb_can_text_frame_parser.sv
// self-checking testbench of the can text frame parser: directed and random frames, scored
module tb_can_text_frame_parser;
   timeunit 1ns;
   timeprecision 1ps;
   import cantp_pkg::*;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int MAX_PL_DIGITS   = PAYLOAD_W / 4;
   localparam int RANDOM_PHASES   = 6;
   localparam int CHARS_PER_PHASE = 200;

   typedef enum logic [1:0] {SCAN_ID, SCAN_HASH, SCAN_PAYLOAD} scan_phase_type;
   typedef enum int {DMG_REPLACE, DMG_DROP, DMG_INSERT, DMG_CUT, DMG_EXTRA, DMG_NOISE}
      damage_type;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
   } text_req_type;

   typedef struct packed {
      logic                 valid;
      logic [ID_W-1:0]      id;
      logic [PAYLOAD_W-1:0] payload;
      logic                 start;
      logic                 stop;
   } frame_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_addr   = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   can_text_frame_parser u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [7:0] text_char
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [11:0] frame_id, [75:12] frame_payload, [79:76] zero
      .rsp_tuser  (rsp_tuser),   // [0] frame_valid, [1] start_flag, [2] stop_flag
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // shadow of the control registers
   logic [ID_W-1:0]      cfg_ctrl_id     = '0;
   logic [PAYLOAD_W-1:0] cfg_stop        = '0;
   logic [PAYLOAD_W-1:0] cfg_start_a     = '0;
   logic [PAYLOAD_W-1:0] cfg_start_b     = '0;
   logic [1:0]           cfg_start_count = '0;

   // frame scanner state
   scan_phase_type       scan_phase = SCAN_ID;
   int                   id_digits  = 0;
   logic [ID_W-1:0]      id_acc     = '0;
   logic [PAYLOAD_W-1:0] pl_acc     = '0;
   int                   pl_digits  = 0;
   logic                 bad_frame  = 1'b0;

   text_req_type     char_queue[$];
   frame_result_type pending_frames[$];
   int               chars_queued   = 0;
   int               chars_accepted = 0;
   int               errors         = 0;
   int               cycles         = 0;
   logic             req_taken      = 1'b0;
   logic             idle_on        = 1'b1;
   int               req_gap        = 0;
   int               rsp_gap        = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // ascii hex digit of either case
   function automatic logic hex_digit(input logic [7:0] c, output logic [3:0] v);
      v = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = 4'(c - 8'h30);
         return 1'b1;
      end
      if (c >= 8'h41 && c <= 8'h46) begin
         v = 4'(c - 8'h41 + 8'd10);
         return 1'b1;
      end
      if (c >= 8'h61 && c <= 8'h66) begin
         v = 4'(c - 8'h61 + 8'd10);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // advance the scanner by one character, queue the frame outcome on the last one
   function automatic void predict_char(input logic [7:0] c, input logic last);
      logic [3:0]       nib;
      logic             is_hex;
      logic             ok;
      logic             special;
      logic             start_hit;
      frame_result_type r;
      is_hex = hex_digit(c, nib);
      if (!bad_frame) begin
         case (scan_phase)
            SCAN_ID: begin
               if (!is_hex) begin
                  bad_frame = 1'b1;
               end else begin
                  id_acc = {id_acc[ID_W-5:0], nib};
                  id_digits++;
                  if (id_digits >= 3) scan_phase = SCAN_HASH;
               end
            end
            SCAN_HASH: begin
               if (c == CHAR_HASH) scan_phase = SCAN_PAYLOAD;
               else bad_frame = 1'b1;
            end
            default: begin
               if (!is_hex || pl_digits >= MAX_PL_DIGITS) begin
                  bad_frame = 1'b1;
               end else begin
                  pl_acc = {pl_acc[PAYLOAD_W-5:0], nib};
                  pl_digits++;
               end
            end
         endcase
      end
      if (last) begin
         ok = !bad_frame && scan_phase == SCAN_PAYLOAD && pl_digits >= 2 && pl_digits % 2 == 0;
         r.valid   = ok;
         r.id      = ok ? id_acc : '0;
         r.payload = ok ? pl_acc : '0;
         special   = r.id == cfg_ctrl_id;
         // a start count of three behaves as two
         start_hit = (cfg_start_count >= 2'd1 && r.payload == cfg_start_a) ||
                     (cfg_start_count >= 2'd2 && r.payload == cfg_start_b);
         r.start   = special && start_hit;
         r.stop    = special && r.payload == cfg_stop;
         pending_frames.push_back(r);
         scan_phase = SCAN_ID;
         id_digits  = 0;
         id_acc     = '0;
         pl_acc     = '0;
         pl_digits  = 0;
         bad_frame  = 1'b0;
      end
   endfunction

   task automatic check_field(input string fname, input logic [79:0] want, input logic [79:0] got);
      if (got !== want) begin
         $error("%s: expected %h, actual %h", fname, want, got);
         errors++;
      end
   endtask

   // request sender
   always @(negedge clock) begin
      text_req_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_taken) begin
         // hold the request until it is taken
      end else if (req_gap > 0) begin
         req_gap--;
         req_tvalid <= 1'b0;
      end else if (char_queue.size() > 0) begin
         if (idle_on && $urandom_range(0, 11) == 0) begin
            req_gap = $urandom_range(0, 7);
            req_tvalid <= 1'b0;
         end else begin
            nxt = char_queue.pop_front();
            req_tdata  <= nxt.ch;
            req_tlast  <= nxt.last;
            req_tvalid <= 1'b1;
         end
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // response receiver stalls
   always @(negedge clock) begin
      if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         rsp_gap = $urandom_range(0, 7);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // accepted requests feed the scanner, responses are scored in order
   always @(posedge clock) begin
      frame_result_type want;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         req_taken = req_tvalid && req_tready;
         if (req_taken) begin
            predict_char(req_tdata, req_tlast);
            chars_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_frames.size() == 0) begin
               $error("response with no frame outstanding: tdata %h tuser %h",
                      rsp_tdata, rsp_tuser);
               errors++;
            end else begin
               want = pending_frames.pop_front();
               check_field("frame_valid", 80'(want.valid), 80'(rsp_tuser[0]));
               check_field("frame_id", 80'(want.id), 80'(rsp_tdata[ID_W-1:0]));
               check_field("frame_payload", 80'(want.payload),
                           80'(rsp_tdata[ID_W +: PAYLOAD_W]));
               check_field("start_flag", 80'(want.start), 80'(rsp_tuser[1]));
               check_field("stop_flag", 80'(want.stop), 80'(rsp_tuser[2]));
               check_field("tdata_pad", '0, 80'(rsp_tdata[RSP_TDATA_W-1:ID_W+PAYLOAD_W]));
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("can_text_frame_parser: mismatch");
         $finish;
      end
   end

   task automatic queue_bytes(input logic [7:0] q[$]);
      text_req_type r;
      for (int i = 0; i < q.size(); i++) begin
         r.ch   = q[i];
         r.last = (i == q.size() - 1);
         char_queue.push_back(r);
         chars_queued++;
      end
   endtask

   task automatic queue_text(input string s);
      logic [7:0] q[$];
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
      queue_bytes(q);
   endtask

   function automatic logic [7:0] hex_ascii(input logic [3:0] n);
      logic upper;
      upper = 1'($urandom_range(0, 1));
      if (n < 4'd10) return 8'h30 + n;
      return (upper ? 8'h41 : 8'h61) + n - 8'd10;
   endfunction

   // well-formed frame text, low ndig digits of the payload
   function automatic void build_frame(ref logic [7:0] q[$], input logic [ID_W-1:0] id,
                                       input logic [PAYLOAD_W-1:0] pl, input int ndig);
      for (int i = 2; i >= 0; i--) q.push_back(hex_ascii(id[4*i +: 4]));
      q.push_back(CHAR_HASH);
      for (int i = ndig - 1; i >= 0; i--) q.push_back(hex_ascii(pl[4*i +: 4]));
   endfunction

   function automatic logic [PAYLOAD_W-1:0] pick_payload();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         2: return PAYLOAD_W'($urandom_range(0, 255));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic add_random_frame();
      logic [7:0]           q[$];
      logic [ID_W-1:0]      id;
      logic [PAYLOAD_W-1:0] pl;
      int                   ndig;
      int                   pos;
      damage_type           dmg;
      // control frames that should hit the start and stop compares
      if ($urandom_range(0, 9) < 3) begin
         id = cfg_ctrl_id;
         case ($urandom_range(0, 2))
            0: pl = cfg_stop;
            1: pl = cfg_start_a;
            default: pl = cfg_start_b;
         endcase
         ndig = (pl < 256 && $urandom_range(0, 1)) ? 2 : MAX_PL_DIGITS;
      end else begin
         id   = ID_W'($urandom_range(0, 4095));
         pl   = {$urandom, $urandom};
         ndig = 2 * $urandom_range(1, MAX_PL_DIGITS / 2);
      end
      build_frame(q, id, pl, ndig);
      // a quarter of the frames get broken
      if ($urandom_range(0, 3) == 0) begin
         dmg = damage_type'($urandom_range(0, 5));
         pos = $urandom_range(0, q.size() - 1);
         case (dmg)
            DMG_REPLACE: q[pos] = 8'($urandom_range(0, 255));
            DMG_DROP:    if (q.size() > 1) q.delete(pos);
            DMG_INSERT:  q.insert(pos, 8'($urandom_range(0, 255)));
            DMG_CUT:     while (q.size() > pos + 1) void'(q.pop_back());
            DMG_EXTRA: begin
               repeat ($urandom_range(1, 2)) q.push_back(hex_ascii(4'($urandom_range(0, 15))));
            end
            default: begin
               q.delete();
               repeat ($urandom_range(1, 6)) q.push_back(8'($urandom_range(0, 255)));
            end
         endcase
      end
      queue_bytes(q);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_CTRL_ID:         cfg_ctrl_id     = val[ID_W-1:0];
         CSR_STOP_VALUE:      cfg_stop        = val;
         CSR_START_PAYLOAD_A: cfg_start_a     = val;
         CSR_START_PAYLOAD_B: cfg_start_b     = val;
         CSR_START_COUNT:     cfg_start_count = val[1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // let every frame come out and the pipeline settle
   task automatic wait_drained();
      while (chars_accepted != chars_queued || pending_frames.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      int target;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // registers at reset: zero id and zero payloads make the stop compare fire
      queue_text("000#00");
      queue_text("fFf#aB");
      queue_text("12#34");
      queue_bytes('{8'h00});
      queue_bytes('{8'hFF});
      queue_text("123#456");
      queue_text("123#");
      queue_text("123#00112233445566778");
      queue_text("FFF#FFFFFFFFFFFFFFFF");
      queue_text("0:0#00");
      queue_text("@AF#00");
      queue_text("`af#0g");
      wait_drained();

      // extreme control values, one start payload, plus writes past the register list
      write_reg(CSR_CTRL_ID, 64'hFFF);
      write_reg(CSR_STOP_VALUE, '1);
      write_reg(CSR_START_PAYLOAD_A, '0);
      write_reg(CSR_START_PAYLOAD_B, 64'h0123_4567_89AB_CDEF);
      write_reg(CSR_START_COUNT, 64'd1);
      for (int k = CSR_START_COUNT + 1; k < 2 ** CSR_ADDR_W; k++) begin
         write_reg(CSR_ADDR_W'(k), {$urandom, $urandom});
      end
      queue_text("FFF#FFFFFFFFFFFFFFFF");
      queue_text("FFF#00");
      queue_text("fff#0123456789abcdef");
      queue_text("FFE#00");
      wait_drained();

      // random phases over several register settings, the third and the last without stalls
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         idle_on = (p != 2 && p != RANDOM_PHASES - 1);
         write_reg(CSR_CTRL_ID, p == 0 ? 64'h0 : p == 1 ? 64'hFFF : 64'($urandom_range(0, 4095)));
         write_reg(CSR_STOP_VALUE, pick_payload());
         write_reg(CSR_START_PAYLOAD_A, pick_payload());
         write_reg(CSR_START_PAYLOAD_B, pick_payload());
         write_reg(CSR_START_COUNT, 64'(p % 4));
         target = chars_queued + CHARS_PER_PHASE;
         while (chars_queued < target) add_random_frame();
         wait_drained();
      end

      repeat (8) @(negedge clock);
      if (errors == 0) begin
         $display("can_text_frame_parser: match");
      end else begin
         $display("can_text_frame_parser: mismatch");
      end
      $finish;
   end

endmodule
